// File: rtl/sst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg
// Shared constants, types and the character encoder for the segment shifter.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam int DIGIT_COUNT = 3;
	localparam int SLOT_W      = 8;
	localparam int FRAME_BITS  = SLOT_W * DIGIT_COUNT;
	localparam int USED_W      = $clog2(DIGIT_COUNT + 1);
	localparam int CNT_W       = $clog2(FRAME_BITS + 1);

	localparam logic [SLOT_W-1:0] DOT_BIT   = 8'h08;
	localparam logic [SLOT_W-1:0] BLANK     = 8'h00;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_DOT  = 8'h2e;
	localparam logic [7:0] CH_D0   = 8'h30;
	localparam logic [7:0] CH_D9   = 8'h39;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UZ   = 8'h5a;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LZ   = 8'h7a;

	localparam logic [SLOT_W-1:0] DIGIT_CODES [10] = '{
		8'h77, 8'h14, 8'hb3, 8'hb6, 8'hd4, 8'he6, 8'he7, 8'h34, 8'hf7, 8'hf6
	};

	localparam logic [SLOT_W-1:0] LETTER_CODES [26] = '{
		8'hf5, 8'hc7, 8'h63, 8'h97, 8'he3,
		8'he1, 8'he7, 8'hc5, 8'h14, 8'h17,
		8'hd5, 8'h43, 8'h75, 8'h85, 8'h77,
		8'hf1, 8'h77, 8'h81, 8'he6, 8'hc3,
		8'h57, 8'h57, 8'h57, 8'hd5, 8'hd4, 8'hb3
	};

	// per-cell controls, driven by the top level
	typedef struct packed {
		logic wr_code;  // write the new code into this slot
		logic or_dot;   // merge a dot into this slot
		logic upd;      // a request is taken this cycle
		logic load;     // frame starts: copy slot into shift stage, clear slot
		logic shift;    // move the shift stage on by one bit
	} slot_ctrl_t;

	function automatic logic [SLOT_W-1:0] encode_char(input logic [7:0] c);
		logic [SLOT_W-1:0] code;
		logic [7:0]        ofs;
		code = BLANK;
		ofs  = 8'h00;
		if (c >= CH_D0 && c <= CH_D9) begin
			ofs  = c - CH_D0;
			code = DIGIT_CODES[ofs[3:0]];
		end else if (c >= CH_LA && c <= CH_LZ) begin
			ofs  = c - CH_LA;
			code = LETTER_CODES[ofs[4:0]];
		end else if (c >= CH_UA && c <= CH_UZ) begin
			ofs  = c - CH_UA;
			code = LETTER_CODES[ofs[4:0]];
		end
		return code;
	endfunction

endpackage

// File: rtl/sst_msg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_msg_if
// Character request channel: one message character per request.
// ----------------------------------------------------------------------------
interface sst_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       message_end;

	modport source (output valid, output character, output message_end, input ready);
	modport sink   (input valid, input character, input message_end, output ready);
endinterface

// File: rtl/sst_bit_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_bit_if
// Serial bit channel: one shifted segment bit per request.
// ----------------------------------------------------------------------------
interface sst_bit_if;
	logic valid;
	logic ready;
	logic serial_bit;
	logic frame_last;

	modport source (output valid, output serial_bit, output frame_last, input ready);
	modport sink   (input valid, input serial_bit, input frame_last, output ready);
endinterface

// File: rtl/seven_segment_text_shifter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_text_shifter
// Encodes message characters into segment slots and shifts each frame out.
// ----------------------------------------------------------------------------
// One character request is taken per cycle. Characters that do not end the
// message are always accepted, also while a frame is shifting. A request with
// message_end set loads the slot cells into the shift chain and is held off
// while the previous frame still has bits to deliver (other than its last bit
// leaving in that cycle). A frame is 8*DIGIT_COUNT serial bits (24), one per
// accepted output request, highest slot first, MSB first, so the shift chain
// sets the sustained rate.
module seven_segment_text_shifter
	import sst_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	sst_msg_if.sink        msg,
	sst_bit_if.source      serial
);

	logic [USED_W-1:0] used_q;
	logic              dot_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              msg_acc;
	logic              ser_acc;
	logic              chain_free;
	logic              is_dot;
	logic              dot_merge;
	logic              room;
	logic              take;
	logic              close;
	logic              load;
	logic [SLOT_W-1:0] code;
	slot_ctrl_t        ctrl [DIGIT_COUNT];
	logic              link [DIGIT_COUNT+1];

	assign ser_acc    = serial.valid && serial.ready;
	assign chain_free = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && serial.ready);
	assign msg.ready  = !msg.message_end || chain_free;
	assign msg_acc    = msg.valid && msg.ready;

	assign is_dot    = msg.character == CH_DOT;
	assign dot_merge = is_dot && dot_q && (used_q != '0);
	assign room      = used_q < USED_W'(DIGIT_COUNT);
	assign take      = (msg.character != CH_NUL) && !dot_merge && room;
	assign close     = (msg.character != CH_NUL) && !dot_merge && !room;
	assign load      = msg_acc && msg.message_end;
	assign code      = encode_char(msg.character);

	always_comb begin
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			ctrl[i].wr_code = take && (used_q == USED_W'(i));
			ctrl[i].or_dot  = dot_merge && (used_q == USED_W'(i + 1));
			ctrl[i].upd     = msg_acc;
			ctrl[i].load    = load;
			ctrl[i].shift   = ser_acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			dot_q  <= 1'b0;
		end else if (load) begin
			used_q <= '0;
			dot_q  <= 1'b0;
		end else if (msg_acc) begin
			if (take) begin
				used_q <= used_q + USED_W'(1);
				dot_q  <= 1'b1;
			end else if (close) begin
				dot_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= CNT_W'(FRAME_BITS);
		end else if (ser_acc) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// slot 0 at the tail, highest slot drives the serial line
	assign link[0] = 1'b0;

	for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_cell
		sst_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl[g]),
			.code      (code),
			.shift_in  (link[g]),
			.chain_out (link[g+1])
		);
	end

	assign serial.valid      = cnt_q != '0;
	assign serial.serial_bit = link[DIGIT_COUNT];
	assign serial.frame_last = cnt_q == CNT_W'(1);

`ifndef NO_ASSERTIONS
	a_cnt_range : assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FRAME_BITS))
		else $error("bit count beyond frame length");

	a_used_range : assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(DIGIT_COUNT))
		else $error("slot count beyond digit count");

	a_load_free : assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && ser_acc))
		else $error("frame loaded over unfinished frame");

	a_load_cnt : assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (cnt_q == CNT_W'(FRAME_BITS)) && (used_q == '0) && !dot_q)
		else $error("frame load did not restart state");
`endif

endmodule

// File: rtl/sst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_cell
// One display slot: the collecting slot byte plus its stage of the shift chain.
// ----------------------------------------------------------------------------
module sst_cell
	import sst_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  slot_ctrl_t        ctrl,
	input  logic [SLOT_W-1:0] code,
	input  logic              shift_in,
	output logic              chain_out
);

	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] shreg_q;
	logic [SLOT_W-1:0] slot_next;

	always_comb begin
		slot_next = slot_q;
		if (ctrl.wr_code) begin
			slot_next = code;
		end else if (ctrl.or_dot) begin
			slot_next = slot_q | DOT_BIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (ctrl.load) begin
			slot_q <= '0;
		end else if (ctrl.upd) begin
			slot_q <= slot_next;
		end
	end

	// load wins over shift: the previous frame's last bit leaves the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shreg_q <= '0;
		end else if (ctrl.load) begin
			shreg_q <= slot_next;
		end else if (ctrl.shift) begin
			shreg_q <= {shreg_q[SLOT_W-2:0], shift_in};
		end
	end

	assign chain_out = shreg_q[SLOT_W-1];

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the seven-segment text shifter: characters go in as
// requests, every serial bit request is checked against a slot predictor.
// ----------------------------------------------------------------------------
module tb_top;
	import sst_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASE_ITEMS    = 68;

	typedef struct packed {
		logic data;
		logic last;
	} seg_bit_t;

	localparam logic [7:0] DIGIT_SEG [10] = '{
		8'h77, 8'h14, 8'hb3, 8'hb6, 8'hd4, 8'he6, 8'he7, 8'h34, 8'hf7, 8'hf6
	};
	localparam logic [7:0] ALPHA_SEG [26] = '{
		8'hf5, 8'hc7, 8'h63, 8'h97, 8'he3, 8'he1, 8'he7, 8'hc5, 8'h14,
		8'h17, 8'hd5, 8'h43, 8'h75, 8'h85, 8'h77, 8'hf1, 8'h77, 8'h81,
		8'he6, 8'hc3, 8'h57, 8'h57, 8'h57, 8'hd5, 8'hd4, 8'hb3
	};

	logic clk;
	logic arst_n;

	sst_msg_if msg ();
	sst_bit_if serial ();

	seven_segment_text_shifter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.serial (serial)
	);

	// predictor state
	logic [7:0]        slot_code [DIGIT_COUNT];
	logic [USED_W-1:0] used_cnt;
	logic              dot_open;
	seg_bit_t          frame_bits_q [$];
	seg_bit_t          head_bit;

	int mismatch_cnt;
	int idle_cycles;
	int src_pct;
	int rx_pct;
	int hold_req;
	int hold_seen;
	int hold_left;
	int items_sent;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [7:0] seg_code(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return DIGIT_SEG[4'(c - "0")];
		if (c >= "a" && c <= "z")
			return ALPHA_SEG[5'(c - "a")];
		if (c >= "A" && c <= "Z")
			return ALPHA_SEG[5'(c - "A")];
		return 8'h00;
	endfunction

	function automatic void clear_slots();
		for (int i = 0; i < DIGIT_COUNT; i++)
			slot_code[i] = 8'h00;
		used_cnt = '0;
		dot_open = 1'b0;
	endfunction

	// takes one character and, on message end, queues the whole frame
	function automatic void absorb_char(input logic [7:0] c, input logic e);
		seg_bit_t sb;
		if (c != CH_NUL) begin
			if (c == CH_DOT && dot_open && used_cnt > 0) begin
				slot_code[used_cnt - USED_W'(1)] = slot_code[used_cnt - USED_W'(1)] | DOT_BIT;
			end else if (used_cnt < DIGIT_COUNT) begin
				slot_code[used_cnt] = seg_code(c);
				used_cnt = used_cnt + USED_W'(1);
				dot_open = 1'b1;
			end else begin
				dot_open = 1'b0;
			end
		end
		if (e) begin
			for (int s = DIGIT_COUNT - 1; s >= 0; s--) begin
				for (int b = 7; b >= 0; b--) begin
					sb.data = slot_code[s][b];
					sb.last = (s == 0 && b == 0);
					frame_bits_q.push_back(sb);
				end
			end
			clear_slots();
		end
	endfunction

	initial clear_slots();

	// result check first: a bit leaving now always belongs to an earlier frame
	always @(posedge clk) begin
		if (arst_n) begin
			if (serial.valid && serial.ready) begin
				if (frame_bits_q.size() == 0) begin
					mismatch_cnt++;
					$display("%0t: unexpected bit: expected none, actual bit %b last %b",
						$time, serial.serial_bit, serial.frame_last);
				end else begin
					head_bit = frame_bits_q.pop_front();
					if (serial.serial_bit !== head_bit.data) begin
						mismatch_cnt++;
						$display("%0t: serial_bit: expected %b, actual %b",
							$time, head_bit.data, serial.serial_bit);
					end
					if (serial.frame_last !== head_bit.last) begin
						mismatch_cnt++;
						$display("%0t: frame_last: expected %b, actual %b",
							$time, head_bit.last, serial.frame_last);
					end
				end
			end
			if (msg.valid && msg.ready)
				absorb_char(msg.character, msg.message_end);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((msg.valid && msg.ready) || (serial.valid && serial.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// output side: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen    <= hold_req;
			hold_left    <= HOLD_CYCLES;
			serial.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			serial.ready <= 1'b0;
		end else begin
			serial.ready <= ($urandom_range(99) >= rx_pct);
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_char(input logic [7:0] c, input logic e);
		while (src_pct > 0 && $urandom_range(99) < src_pct) begin
			msg.valid       <= 1'b0;
			msg.character   <= 8'($urandom_range(255));
			msg.message_end <= 1'($urandom_range(1));
			@(negedge clk);
		end
		msg.valid       <= 1'b1;
		msg.character   <= c;
		msg.message_end <= e;
		@(posedge clk);
		while (!msg.ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	task automatic wait_drain();
		msg.valid <= 1'b0;
		do
			@(negedge clk);
		while (frame_bits_q.size() != 0);
	endtask

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return 8'("0" + $urandom_range(9));
		if (r < 35)
			return 8'("a" + $urandom_range(25));
		if (r < 45)
			return 8'("A" + $urandom_range(25));
		if (r < 70)
			return CH_DOT;
		if (r < 77)
			return CH_NUL;
		return 8'($urandom_range(255));
	endfunction

	task automatic test_directed();
		send_text("09z");
		send_char(CH_NUL, 1'b1);             // empty frame
		send_text("A..Za");
		send_text("..7.");                   // leading dot takes a blank slot
		send_text("123.4.");                 // slots full: dot merges, later chars ignored
		send_char(8'hff, 1'b0);
		send_char(8'h80, 1'b0);
		send_char(8'h7f, 1'b1);
		send_char("5", 1'b0);
		send_char(CH_NUL, 1'b0);             // zero keeps the dot chain open
		send_char(CH_DOT, 1'b1);
		send_text("/:@");
		send_text("[`{");
		wait_drain();
	endtask

	task automatic test_backpressure();
		hold_req++;
		// the second and third message ends must each wait for the frame before them
		send_text("8.8.8.");
		send_text("b2Y");
		send_text("E.1");
		wait_drain();
	endtask

	task automatic test_random(input int sp, input int rp);
		int start;
		int len;
		src_pct = sp;
		rx_pct  = rp;
		start   = items_sent;
		while (items_sent - start < PHASE_ITEMS) begin
			// mostly short messages, now and then an overlong one
			len = ($urandom_range(9) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 4);
			repeat (len)
				send_char(pick_char(), 1'b0);
			send_char(pick_char(), 1'b1);
		end
		wait_drain();
	endtask

	initial begin
		arst_n             = 1'b0;
		msg.valid          = 1'b0;
		msg.character      = 8'h00;
		msg.message_end    = 1'b0;
		serial.ready       = 1'b0;
		mismatch_cnt       = 0;
		idle_cycles        = 0;
		src_pct            = 0;
		rx_pct             = 0;
		hold_req           = 0;
		hold_seen          = 0;
		hold_left          = 0;
		items_sent         = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_backpressure();
		test_random(0, 0);
		test_random(71, 0);
		test_random(0, 71);
		test_random(29, 29);
		test_random(0, 0);

		src_pct = 0;
		rx_pct  = 0;
		repeat (40) @(negedge clk);
		if (mismatch_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/sst_pkg.sv
rtl/sst_msg_if.sv
rtl/sst_bit_if.sv
rtl/sst_cell.sv
rtl/seven_segment_text_shifter.sv
test/tb_top.sv
